### rtl/core/dcim_pkg.sv
// ----------------------------------------------------------------------------
// dcim_pkg: shared types and constants of the detector channel index mapper
// geometry of the detector, field widths, level and error codes, and the
// reciprocal constants used for the mixed-radix unpacking
// ----------------------------------------------------------------------------
package dcim_pkg;

  // field widths
  localparam int GLB_W = 14;
  localparam int SEC_W = 2;
  localparam int LAY_W = 4;
  localparam int SCT_W = 3;
  localparam int PLN_W = 2;
  localparam int ELM_W = 7;
  localparam int ERR_W = 3;
  localparam int LVL_W = 3;

  // detector geometry
  localparam int LAYERS_BACKWARD    = 12;
  localparam int LAYERS_FORWARD     = 14;
  localparam int SECTORS_PER_LAYER  = 4;
  localparam int PLANES_PER_SECTOR  = 2;
  localparam int SEGMENTS_PER_PLANE = 5;
  localparam int STRIPS_PER_PLANE   = 75;

  localparam int TOTAL_LAYERS = LAYERS_BACKWARD + LAYERS_FORWARD;
  localparam int ELEM_MAX = (SEGMENTS_PER_PLANE > STRIPS_PER_PLANE) ?
                            SEGMENTS_PER_PLANE : STRIPS_PER_PLANE;
  localparam int PLANES_SECTORS = PLANES_PER_SECTOR * SECTORS_PER_LAYER;

  // largest global number per level
  localparam int MAX_LAYER_LVL  = TOTAL_LAYERS;
  localparam int MAX_SECTOR_LVL = MAX_LAYER_LVL * SECTORS_PER_LAYER;
  localparam int MAX_PLANE_LVL  = MAX_SECTOR_LVL * PLANES_PER_SECTOR;
  localparam int MAX_SEG_LVL    = MAX_PLANE_LVL * SEGMENTS_PER_PLANE;
  localparam int MAX_STRIP_LVL  = MAX_PLANE_LVL * STRIPS_PER_PLANE;
  localparam int MAX_ENC        = MAX_PLANE_LVL * ELEM_MAX;

  // internal value width: holds the unmasked encoded number and the decode input
  localparam int ENC_W = $clog2(MAX_ENC + 1);
  localparam int VAL_W = (ENC_W > GLB_W) ? ENC_W : GLB_W;

  // remainder below sector level, plane and sector packed together
  localparam int RW = $clog2(PLANES_SECTORS + 1);

  // exact division by multiply: q = (x * ceil(2^sh / d)) >> sh for x < 2^GLB_W
  localparam int SH1      = GLB_W + ELM_W;
  localparam int M1_W     = SH1 + 1;
  localparam int M1_SEG   = ((2 ** SH1) + SEGMENTS_PER_PLANE - 1) / SEGMENTS_PER_PLANE;
  localparam int M1_STRIP = ((2 ** SH1) + STRIPS_PER_PLANE - 1) / STRIPS_PER_PLANE;

  localparam int SH2    = GLB_W + RW;
  localparam int M2_W   = SH2 + 1;
  localparam int M2_PS  = ((2 ** SH2) + PLANES_SECTORS - 1) / PLANES_SECTORS;
  localparam int M2_S   = ((2 ** SH2) + SECTORS_PER_LAYER - 1) / SECTORS_PER_LAYER;
  localparam int M2_ONE = 2 ** SH2;

  localparam logic [SEC_W-1:0] SEC_BACKWARD = 2'd1;
  localparam logic [SEC_W-1:0] SEC_FORWARD  = 2'd2;

  typedef enum logic [LVL_W-1:0] {
    LVL_LAYER   = 3'd0,
    LVL_SECTOR  = 3'd1,
    LVL_PLANE   = 3'd2,
    LVL_SEGMENT = 3'd3,
    LVL_STRIP   = 3'd4
  } level_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK      = 3'd0,
    ERR_SECTION = 3'd1,
    ERR_LAYER   = 3'd2,
    ERR_SECTOR  = 3'd3,
    ERR_PLANE   = 3'd4,
    ERR_ELEMENT = 3'd5,
    ERR_GLOBAL  = 3'd6
  } err_t;

endpackage

### rtl/core/detector_channel_index_mapper_core.sv
// ----------------------------------------------------------------------------
// detector_channel_index_mapper_core: channel address flatten / unflatten
// converts a section/layer/sector/plane/element address into a 1-based global
// number at a chosen level, or a global number back into that address
// ----------------------------------------------------------------------------
// usage
//   requests enter on in_valid/in_ready with req_type (0 encode, 1 decode),
//   level and the address or global fields; one result per request leaves
//   on out_valid/out_ready with the fields and error_code.
//   the datapath is five register stages: range checks and the first
//   offset, then one constant multiply per stage (sector, plane, element
//   scaling on encode; reciprocal divides and remainders on decode), and the
//   output register. throughput is one request per cycle while out_ready
//   is high, set by the stage pipeline; no loop feeds back between
//   requests.
//   each stage has its own valid bit and loads whenever it is empty or its
//   successor moves, so bubbles close up and in_ready stays high while any
//   stage is free. when the receiver holds out_ready low the output register
//   keeps its result and the stages behind it fill up before in_ready drops.
//   reset empties all stages; no request is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module detector_channel_index_mapper_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [dcim_pkg::LVL_W-1:0] level,
  input  logic [dcim_pkg::SEC_W-1:0] in_section,
  input  logic [dcim_pkg::LAY_W-1:0] in_layer,
  input  logic [dcim_pkg::SCT_W-1:0] in_sector,
  input  logic [dcim_pkg::PLN_W-1:0] in_plane,
  input  logic [dcim_pkg::ELM_W-1:0] in_element,
  input  logic [dcim_pkg::GLB_W-1:0] in_global,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dcim_pkg::GLB_W-1:0] out_global,
  output logic [dcim_pkg::SEC_W-1:0] out_section,
  output logic [dcim_pkg::LAY_W-1:0] out_layer,
  output logic [dcim_pkg::SCT_W-1:0] out_sector,
  output logic [dcim_pkg::PLN_W-1:0] out_plane,
  output logic [dcim_pkg::ELM_W-1:0] out_element,
  output logic [dcim_pkg::ERR_W-1:0] error_code
);
  import dcim_pkg::*;

  // stage valid bits and load enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5       = !v5 || out_ready;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // ---------------- stage 1: checks and starting value ----------------
  level_t            lvl_c;
  err_t              err_c;
  logic [ELM_W-1:0]  elm_lim;
  logic [LAY_W-1:0]  lay_lim;
  logic [VAL_W-1:0]  dec_max;
  logic [VAL_W-1:0]  val_c;

  always_comb begin
    lvl_c   = (level > LVL_STRIP) ? LVL_STRIP : level_t'(level);
    elm_lim = (lvl_c == LVL_SEGMENT) ? ELM_W'(SEGMENTS_PER_PLANE) : ELM_W'(STRIPS_PER_PLANE);
    lay_lim = (in_section == SEC_BACKWARD) ? LAY_W'(LAYERS_BACKWARD) : LAY_W'(LAYERS_FORWARD);
    unique case (lvl_c)
      LVL_LAYER:   dec_max = VAL_W'(MAX_LAYER_LVL);
      LVL_SECTOR:  dec_max = VAL_W'(MAX_SECTOR_LVL);
      LVL_PLANE:   dec_max = VAL_W'(MAX_PLANE_LVL);
      LVL_SEGMENT: dec_max = VAL_W'(MAX_SEG_LVL);
      default:     dec_max = VAL_W'(MAX_STRIP_LVL);
    endcase
    err_c = ERR_OK;
    if (req_type) begin
      if (in_global == '0 || VAL_W'(in_global) > dec_max) err_c = ERR_GLOBAL;
      val_c = VAL_W'(in_global) - VAL_W'(1);
    end else begin
      // innermost field is checked first
      priority if (lvl_c >= LVL_SEGMENT && (in_element == '0 || in_element > elm_lim))
        err_c = ERR_ELEMENT;
      else if (lvl_c >= LVL_PLANE &&
               (in_plane == '0 || in_plane > PLN_W'(PLANES_PER_SECTOR)))
        err_c = ERR_PLANE;
      else if (lvl_c >= LVL_SECTOR &&
               (in_sector == '0 || in_sector > SCT_W'(SECTORS_PER_LAYER)))
        err_c = ERR_SECTOR;
      else if (in_section != SEC_BACKWARD && in_section != SEC_FORWARD)
        err_c = ERR_SECTION;
      else if (in_layer == '0 || in_layer > lay_lim)
        err_c = ERR_LAYER;
      else
        err_c = ERR_OK;
      // zero-based global layer
      val_c = VAL_W'(in_layer) - VAL_W'(1) +
              ((in_section == SEC_BACKWARD) ? '0 : VAL_W'(LAYERS_BACKWARD));
    end
  end

  logic              s1_req;
  level_t            s1_lvl;
  err_t              s1_err;
  logic [VAL_W-1:0]  s1_val;
  logic [SCT_W-1:0]  s1_sct;
  logic [PLN_W-1:0]  s1_pln;
  logic [ELM_W-1:0]  s1_elm;

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_req <= req_type;
      s1_lvl <= lvl_c;
      s1_err <= err_c;
      s1_val <= val_c;
      s1_sct <= in_sector - SCT_W'(1);
      s1_pln <= in_plane - PLN_W'(1);
      s1_elm <= in_element - ELM_W'(1);
    end
  end

  // ---------------- stage 2: sector scale / element quotient ----------------
  logic [VAL_W-1:0]      enc_a;
  logic [M1_W-1:0]       m1_sel;
  logic [GLB_W+M1_W-1:0] prod1;
  logic [GLB_W-1:0]      qe;

  always_comb begin
    enc_a = (s1_lvl >= LVL_SECTOR) ?
            VAL_W'(s1_val * SECTORS_PER_LAYER) + VAL_W'(s1_sct) : s1_val;
    m1_sel = (s1_lvl == LVL_SEGMENT) ? M1_W'(M1_SEG) : M1_W'(M1_STRIP);
    prod1  = (GLB_W+M1_W)'(s1_val[GLB_W-1:0]) * (GLB_W+M1_W)'(m1_sel);
    qe     = (s1_lvl >= LVL_SEGMENT) ? prod1[SH1 +: GLB_W] : s1_val[GLB_W-1:0];
  end

  logic              s2_req;
  level_t            s2_lvl;
  err_t              s2_err;
  logic [VAL_W-1:0]  s2_val;
  logic [GLB_W-1:0]  s2_q;
  logic [PLN_W-1:0]  s2_pln;
  logic [ELM_W-1:0]  s2_elm;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_req <= s1_req;
      s2_lvl <= s1_lvl;
      s2_err <= s1_err;
      s2_val <= s1_req ? s1_val : enc_a;
      s2_q   <= qe;
      s2_pln <= s1_pln;
      s2_elm <= s1_elm;
    end
  end

  // ---------------- stage 3: plane scale / element digit, layer quotient ----------------
  logic [VAL_W-1:0]      enc_b;
  logic [VAL_W-1:0]      elm_prod;
  logic [VAL_W-1:0]      elm_rem;
  logic [M2_W-1:0]       m2_sel;
  logic [GLB_W+M2_W-1:0] prod2;

  always_comb begin
    enc_b = (s2_lvl >= LVL_PLANE) ?
            VAL_W'(s2_val * PLANES_PER_SECTOR) + VAL_W'(s2_pln) : s2_val;
    elm_prod = (s2_lvl == LVL_SEGMENT) ? VAL_W'(s2_q * SEGMENTS_PER_PLANE) :
                                         VAL_W'(s2_q * STRIPS_PER_PLANE);
    elm_rem  = s2_val - elm_prod;
    priority if (s2_lvl >= LVL_PLANE) m2_sel = M2_W'(M2_PS);
    else if (s2_lvl == LVL_SECTOR)    m2_sel = M2_W'(M2_S);
    else                              m2_sel = M2_W'(M2_ONE);
    prod2 = (GLB_W+M2_W)'(s2_q) * (GLB_W+M2_W)'(m2_sel);
  end

  logic              s3_req;
  level_t            s3_lvl;
  err_t              s3_err;
  logic [VAL_W-1:0]  s3_val;
  logic [GLB_W-1:0]  s3_q;
  logic [ELM_W-1:0]  s3_elm;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_req <= s2_req;
      s3_lvl <= s2_lvl;
      s3_err <= s2_err;
      s3_val <= s2_req ? VAL_W'(s2_q) : enc_b;
      s3_q   <= prod2[SH2 +: GLB_W];
      s3_elm <= s2_req ? elm_rem[ELM_W-1:0] : s2_elm;
    end
  end

  // ---------------- stage 4: element scale / plane-sector remainder, section ----------------
  logic [VAL_W-1:0]  enc_c;
  logic [VAL_W-1:0]  ps_prod;
  logic [VAL_W-1:0]  ps_rem;
  logic [GLB_W-1:0]  lay_g;
  logic [SEC_W-1:0]  sec_d;
  logic [LAY_W-1:0]  lay_d;

  always_comb begin
    unique case (s3_lvl)
      LVL_SEGMENT: enc_c = VAL_W'(s3_val * SEGMENTS_PER_PLANE) + VAL_W'(s3_elm);
      LVL_STRIP:   enc_c = VAL_W'(s3_val * STRIPS_PER_PLANE) + VAL_W'(s3_elm);
      default:     enc_c = s3_val;
    endcase
    priority if (s3_lvl >= LVL_PLANE) ps_prod = VAL_W'(s3_q * PLANES_SECTORS);
    else if (s3_lvl == LVL_SECTOR)    ps_prod = VAL_W'(s3_q * SECTORS_PER_LAYER);
    else                              ps_prod = VAL_W'(s3_q);
    ps_rem = s3_val - ps_prod;
    lay_g  = s3_q + GLB_W'(1);
    if (lay_g <= GLB_W'(LAYERS_BACKWARD)) begin
      sec_d = SEC_BACKWARD;
      lay_d = lay_g[LAY_W-1:0];
    end else begin
      sec_d = SEC_FORWARD;
      lay_d = LAY_W'(lay_g - GLB_W'(LAYERS_BACKWARD));
    end
  end

  logic              s4_req;
  level_t            s4_lvl;
  err_t              s4_err;
  logic [VAL_W-1:0]  s4_val;
  logic [RW-1:0]     s4_rem;
  logic [SEC_W-1:0]  s4_sec;
  logic [LAY_W-1:0]  s4_lay;
  logic [ELM_W-1:0]  s4_elm;

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      s4_req <= s3_req;
      s4_lvl <= s3_lvl;
      s4_err <= s3_err;
      s4_val <= enc_c + VAL_W'(1);
      s4_rem <= ps_rem[RW-1:0];
      s4_sec <= sec_d;
      s4_lay <= lay_d;
      s4_elm <= s3_elm;
    end
  end

  // ---------------- stage 5: split plane and sector, output register ----------------
  logic [SCT_W-1:0]  sct_i;
  logic [RW-1:0]     pln_i;
  logic              enc_ok;
  logic              dec_ok;

  always_comb begin
    sct_i = '0;
    pln_i = s4_rem;
    if (s4_lvl >= LVL_PLANE) begin
      // remainder is sector * planes + plane, split by compare with constants
      for (int k = 1; k < SECTORS_PER_LAYER; k++) begin
        if (s4_rem >= RW'(k * PLANES_PER_SECTOR)) begin
          sct_i = SCT_W'(k);
          pln_i = s4_rem - RW'(k * PLANES_PER_SECTOR);
        end
      end
    end else begin
      sct_i = SCT_W'(s4_rem);
    end
    enc_ok = !s4_req && s4_err == ERR_OK;
    dec_ok = s4_req && s4_err == ERR_OK;
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      out_global  <= enc_ok ? s4_val[GLB_W-1:0] : '0;
      out_section <= dec_ok ? s4_sec : '0;
      out_layer   <= dec_ok ? s4_lay : '0;
      out_sector  <= (dec_ok && s4_lvl >= LVL_SECTOR) ? sct_i + SCT_W'(1) : '0;
      out_plane   <= (dec_ok && s4_lvl >= LVL_PLANE) ?
                     PLN_W'(pln_i) + PLN_W'(1) : '0;
      out_element <= (dec_ok && s4_lvl >= LVL_SEGMENT) ? s4_elm + ELM_W'(1) : '0;
      error_code  <= s4_err;
    end
  end

  // ---------------- assertions ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_OK |->
      out_global == '0 && out_section == '0 && out_layer == '0 &&
      out_sector == '0 && out_plane == '0 && out_element == '0)
    else $error("error result carries nonzero fields");

  a_dec_section: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_OK && out_global == '0 |->
      (out_section == SEC_BACKWARD || out_section == SEC_FORWARD) && out_layer != '0)
    else $error("decoded result without a valid section and layer");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted request did not reach the first stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !en5 |=> v4 && $stable(s4_val) && $stable(s4_err))
    else $error("stalled stage lost or changed its request");

endmodule
